>>> hdl/matrix3_inverse_unit_macros.svh
// Assertion macros shared by the checker of the matrix inverse unit.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef MATRIX3_INVERSE_UNIT_MACROS_SVH
`define MATRIX3_INVERSE_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define M3I_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define M3I_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hdl/m3inv_pkg.sv
// Types and constants of the 3x3 matrix inverse unit.
// Depends on nothing; used by the front, queue, back and top modules of the unit.
package m3inv_pkg;
  localparam int ElemW = 32;
  localparam int CofW  = 64;
  localparam int DetW  = 97;
  localparam int DivW  = 96;  // magnitude of the determinant
  localparam int NumW  = 96;  // cofactor magnitude times 2^32
  localparam int QW    = 42;  // capped quotient width, one spare bit for the shift
  localparam int Steps = 96;  // dividend bits fed to the divider
  localparam logic [QW-1:0] QCap = QW'(1) << 40;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef elem_t mat_t [9];

  // Classified job handed from the front part to the back part.
  typedef struct packed {
    logic [8:0][ElemW-1:0] elems;  // input, for the singular echo
    logic [8:0][CofW-1:0]  cmag;   // cofactor magnitudes
    logic [8:0]            cneg;   // cofactor signs
    logic [DivW-1:0]       dmag;   // determinant magnitude
    logic                  dneg;
    logic                  singular;
  } job_t;
endpackage

>>> hdl/m3inv_front.sv
// Front part: accepts matrices, forms cofactors and determinant in stages.
// Depends on m3inv_pkg.
module m3inv_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [9*32-1:0]       in_data,
  output logic                  job_valid,
  input  logic                  job_ready,
  output m3inv_pkg::job_t       job
);
  // Stage 1: products. Stage 2: cofactors. Stage 3: partial products of
  // det (32 x 64 each, split as two 32 x 32). Stage 4: det sum and classify.
  logic [3:0] vld;
  logic       adv;
  assign adv      = !vld[3] || job_ready;
  assign in_ready = adv;
  assign job_valid = vld[3];

  logic signed [31:0] e1 [9];
  logic signed [63:0] pr [18];
  logic signed [31:0] e2 [9];
  logic signed [63:0] c2 [9];
  logic signed [31:0] e3 [9];
  logic signed [63:0] c3 [9];
  logic signed [95:0] plo [3];
  logic signed [95:0] phi [3];
  m3inv_pkg::job_t    j4;
  logic signed [m3inv_pkg::DetW-1:0] det;
  logic [m3inv_pkg::DivW-1:0]        dmag;

  logic signed [31:0] e [9];
  always_comb begin
    for (int i = 0; i < 9; i++) e[i] = in_data[i*32 +: 32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1 <= e;
      pr[0]  <= e[4] * e[8];  pr[1]  <= e[5] * e[7];
      pr[2]  <= e[2] * e[7];  pr[3]  <= e[1] * e[8];
      pr[4]  <= e[1] * e[5];  pr[5]  <= e[2] * e[4];
      pr[6]  <= e[5] * e[6];  pr[7]  <= e[3] * e[8];
      pr[8]  <= e[0] * e[8];  pr[9]  <= e[2] * e[6];
      pr[10] <= e[2] * e[3];  pr[11] <= e[0] * e[5];
      pr[12] <= e[3] * e[7];  pr[13] <= e[4] * e[6];
      pr[14] <= e[1] * e[6];  pr[15] <= e[0] * e[7];
      pr[16] <= e[0] * e[4];  pr[17] <= e[1] * e[3];
      e2 <= e1;
      for (int i = 0; i < 9; i++) c2[i] <= pr[2*i] - pr[2*i+1];
      e3 <= e2;
      c3 <= c2;
      // Signed 32 x 64 split into signed high and unsigned low halves.
      for (int k = 0; k < 3; k++) begin
        plo[k] <= 96'(e2[3*k]) * $signed({1'b0, c2[k][31:0]});
        phi[k] <= 96'(e2[3*k]) * 96'($signed(c2[k][63:32]));
      end
      for (int i = 0; i < 9; i++) begin
        j4.elems[i] <= e3[i];
        j4.cneg[i]  <= c3[i][63];
        j4.cmag[i]  <= c3[i][63] ? 64'(-c3[i]) : c3[i];
      end
      j4.dmag     <= dmag;
      j4.dneg     <= det[m3inv_pkg::DetW-1];
      j4.singular <= (det == '0);
    end
  end

  always_comb begin
    det = '0;
    for (int k = 0; k < 3; k++)
      det = det + m3inv_pkg::DetW'(plo[k]) + (m3inv_pkg::DetW'(phi[k]) <<< 32);
    dmag = det[m3inv_pkg::DetW-1] ? m3inv_pkg::DivW'(-det) : m3inv_pkg::DivW'(det);
  end

  assign job = j4;
endmodule

>>> hdl/m3inv_queue.sv
// Short queue between the front and back parts.
// Depends on m3inv_pkg.
module m3inv_queue #(
  parameter int Depth = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  m3inv_pkg::job_t wr_job,
  output logic            rd_valid,
  input  logic            rd_ready,
  output m3inv_pkg::job_t rd_job
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  m3inv_pkg::job_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic wr, rd;
  assign wr_ready = cnt != (AW+1)'(Depth);
  assign rd_valid = cnt != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_job = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_job;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr) wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      if (rd) rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

>>> hdl/m3inv_back.sv
// Back part: nine restoring divider lanes, one per cofactor, step in lockstep and retire
// four quotient bits a cycle; a stalled output holds the last step. Depends on m3inv_pkg.
module m3inv_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  m3inv_pkg::job_t  job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [9*32+1:0]  out_word
);
  localparam int BPC = 4;
  localparam int NCyc = m3inv_pkg::Steps / BPC;
  localparam int RW = m3inv_pkg::DivW + 1;
  localparam int NW = m3inv_pkg::NumW;

  logic                     busy;
  logic [$clog2(NCyc)-1:0]  cyc;
  m3inv_pkg::job_t          cur;
  logic [RW-1:0]            rem [9];
  logic [m3inv_pkg::QW-1:0] q   [9];
  logic [NW-1:0]            num [9];
  logic                     obusy;
  logic [9*32+1:0]          oreg;
  logic                     done;

  logic [RW-1:0]            rem_n [9];
  logic [m3inv_pkg::QW-1:0] q_n   [9];
  logic [NW-1:0]            num_n [9];
  always_comb begin
    for (int l = 0; l < 9; l++) begin
      rem_n[l] = rem[l];
      q_n[l]   = q[l];
      num_n[l] = num[l];
      for (int s = 0; s < BPC; s++) begin
        rem_n[l] = {rem_n[l][RW-2:0], num_n[l][NW-1]};
        num_n[l] = num_n[l] << 1;
        q_n[l]   = q_n[l] << 1;
        if (rem_n[l] >= RW'(cur.dmag)) begin
          rem_n[l] = rem_n[l] - RW'(cur.dmag);
          q_n[l][0] = 1'b1;
        end
        if (q_n[l] >= m3inv_pkg::QCap) q_n[l] = m3inv_pkg::QCap;
      end
    end
  end

  assign done      = busy && (cyc == $bits(cyc)'(NCyc-1));
  assign job_ready = !busy && (!obusy || out_ready);
  assign out_valid = obusy;
  assign out_word  = oreg;

  logic [9*32+1:0] res;
  always_comb begin
    logic sat;
    logic [m3inv_pkg::QW-1:0] qq;
    sat = 1'b0;
    res = '0;
    for (int l = 0; l < 9; l++) begin
      qq = q_n[l];
      if (cur.cneg[l] != cur.dneg) begin
        if (qq > m3inv_pkg::QW'(32'h8000_0000)) begin
          qq = m3inv_pkg::QW'(32'h8000_0000); sat = 1'b1;
        end
        res[l*32 +: 32] = 32'(-qq);
      end else begin
        if (qq > m3inv_pkg::QW'(32'h7fff_ffff)) begin
          qq = m3inv_pkg::QW'(32'h7fff_ffff); sat = 1'b1;
        end
        res[l*32 +: 32] = qq[31:0];
      end
    end
    res[9*32+1] = sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; obusy <= 1'b0; cyc <= '0;
    end else begin
      if (out_ready) obusy <= 1'b0;
      if (job_valid && job_ready) begin
        if (job.singular) begin
          obusy <= 1'b1;
        end else begin
          busy <= 1'b1;
          cyc  <= '0;
        end
      end else if (busy) begin
        cyc <= cyc + 1'b1;
        if (done && (!obusy || out_ready)) begin
          busy  <= 1'b0;
          obusy <= 1'b1;
        end else if (done) begin
          cyc <= cyc;
        end
      end
    end
  end

  // The top 32 bits of the dividend are zero and add nothing to the
  // quotient, so the lanes start from the cofactor bits.
  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      cur <= job;
      for (int l = 0; l < 9; l++) begin
        rem[l] <= '0;
        q[l]   <= '0;
        num[l] <= {job.cmag[l], 32'b0};
      end
      if (job.singular) oreg <= {1'b0, 1'b1, job.elems};
    end else if (busy && !(done && obusy && !out_ready)) begin
      rem <= rem_n; q <= q_n; num <= num_n;
      if (done) oreg <= res;
    end
  end
endmodule

>>> hdl/matrix3_inverse_unit.sv
// Usage of the 3x3 matrix inverse unit (adjugate method, Q16.16).
// Slave channel s_axis_*: one request per matrix, nine signed Q16.16
// elements in tdata, column-major (r0c0 in the lowest 32 bits).
// Master channel m_axis_*: one result per request, the nine inverse
// elements in the same order, then singular and saturated in tuser.
// The front part is a four stage pipeline forming cofactors and the
// determinant; it takes a request every cycle while the queue has room.
// The back part holds nine divider lanes that retire 4 quotient bits a
// cycle over 96 dividend bits, the last step waiting for a free result
// register; it takes the next matrix only once the last has handed its
// result over. A singular matrix skips the divider and its input
// elements are echoed as the result. A stalled receiver holds the result
// register; the queue then fills and s_axis_tready drops. Synchronous
// reset empties all stages and the queue.
module matrix3_inverse_unit #(
  parameter int QueueDepth = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [287:0]   s_axis_tdata,  // r0c0,r1c0,r2c0,r0c1,...,r2c2
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [287:0]   m_axis_tdata,  // out_r0c0 ... out_r2c2
  output logic [1:0]     m_axis_tuser   // singular, saturated
);
  m3inv_pkg::job_t fjob, qjob;
  logic fv, fr, qv, qr;
  logic [289:0] word;

  m3inv_front u_front (.clk, .rst, .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .job_valid(fv), .job_ready(fr), .job(fjob));
  m3inv_queue #(.Depth(QueueDepth)) u_queue (.clk, .rst, .wr_valid(fv),
    .wr_ready(fr), .wr_job(fjob), .rd_valid(qv), .rd_ready(qr), .rd_job(qjob));
  m3inv_back u_back (.clk, .rst, .job_valid(qv), .job_ready(qr), .job(qjob),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_word(word));

  assign m_axis_tdata = word[287:0];
  assign m_axis_tuser = word[289:288];
endmodule

>>> hdl/m3inv_checker.sv
// Port-level checker for the matrix inverse unit, bound to the top level.
// Depends on matrix3_inverse_unit_macros.svh.
`include "matrix3_inverse_unit_macros.svh"
module m3inv_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [287:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);
  `M3I_ASSERT_NEXT(hold_valid, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  `M3I_ASSERT_NEXT(hold_data, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
  `M3I_ASSERT_IMP(flags_excl, clk, rst, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "singular result marked saturated")
endmodule

bind matrix3_inverse_unit m3inv_checker u_chk (.clk, .rst, .m_axis_tvalid,
  .m_axis_tready, .m_axis_tdata, .m_axis_tuser);

>>> tb/tb_top.sv
// Self-checking testbench of the 3x3 matrix inverse unit (adjugate method, Q16.16).
// Depends on the unit top level only; the expected inverse is computed here at full width.
module tb_top;

  localparam int IdleLimit = 4000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata;   // r0c0,r1c0,r2c0,r0c1,r1c1,r2c1,r0c2,r1c2,r2c2
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [287:0] m_axis_tdata;   // out_r0c0 ... out_r2c2, same order as the request
  logic [1:0]   m_axis_tuser;   // singular, saturated

  logic [287:0] matrix_queue[$];
  logic [289:0] inverse_queue[$];  // {saturated, singular, elements}
  int           cycle_count;
  int           idle_cycles;
  int           mismatches;
  bit           stimulus_done;

  matrix3_inverse_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Exact adjugate inverse: cofactors at 64 bits, determinant at 128 bits.
  function automatic logic [289:0] invert(input logic [287:0] m);
    logic signed [63:0]  e[9];
    logic signed [63:0]  c[9];
    logic signed [127:0] ew[3];
    logic signed [127:0] cw[3];
    logic signed [127:0] det;
    logic [127:0]        dmag;
    logic [127:0]        cmag;
    logic [127:0]        q;
    logic [287:0]        o;
    logic                sat;
    logic                neg;
    int                  i;
    sat = 1'b0;
    for (i = 0; i < 9; i++) e[i] = $signed(m[32*i +: 32]);
    c[0] = e[4] * e[8] - e[5] * e[7];
    c[1] = e[2] * e[7] - e[1] * e[8];
    c[2] = e[1] * e[5] - e[2] * e[4];
    c[3] = e[5] * e[6] - e[3] * e[8];
    c[4] = e[0] * e[8] - e[2] * e[6];
    c[5] = e[2] * e[3] - e[0] * e[5];
    c[6] = e[3] * e[7] - e[4] * e[6];
    c[7] = e[1] * e[6] - e[0] * e[7];
    c[8] = e[0] * e[4] - e[1] * e[3];
    for (i = 0; i < 3; i++) begin
      ew[i] = e[3*i];
      cw[i] = c[i];
    end
    det = ew[0] * cw[0] + ew[1] * cw[1] + ew[2] * cw[2];
    if (det == 0) return {2'b01, m};
    dmag = det < 0 ? -det : det;
    for (i = 0; i < 9; i++) begin
      cw[0] = c[i];
      cmag = cw[0] < 0 ? -cw[0] : cw[0];
      q = (cmag << 32) / dmag;
      neg = (c[i] < 0) != (det < 0);
      if (neg) begin
        if (q > 128'h8000_0000) begin
          q = 128'h8000_0000;
          sat = 1'b1;
        end
        o[32*i +: 32] = 32'(-q);
      end else begin
        if (q > 128'h7FFF_FFFF) begin
          q = 128'h7FFF_FFFF;
          sat = 1'b1;
        end
        o[32*i +: 32] = q[31:0];
      end
    end
    return {sat, 1'b0, o};
  endfunction

  function automatic logic [287:0] diagonal(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
    logic [287:0] m;
    m = '0;
    m[0 +: 32]   = a;
    m[128 +: 32] = b;
    m[256 +: 32] = c;
    return m;
  endfunction

  function automatic logic [31:0] small_elem();
    return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
  endfunction

  function automatic logic [287:0] random_matrix();
    logic [287:0] m;
    int           kind;
    int           i;
    kind = $urandom_range(0, 99);
    for (i = 0; i < 9; i++) begin
      if (kind < 30) m[32*i +: 32] = $urandom();
      else if (kind < 75) m[32*i +: 32] = small_elem();
      else m[32*i +: 32] = 32'($signed($urandom_range(0, 8)) - 4) << $urandom_range(10, 20);
    end
    // r0c0 copied to r2c0, or column 0 copied to column 1 and maybe one element redrawn.
    if (kind >= 85 && kind < 92) m[64 +: 32] = m[0 +: 32];
    if (kind >= 92) begin
      m[96 +: 96] = m[0 +: 96];
      if ($urandom_range(0, 1)) m[32*$urandom_range(0, 8) +: 32] = $urandom();
    end
    return m;
  endfunction

  initial begin
    logic [287:0] m;
    int           i;
    rst = 1'b1;
    stimulus_done = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    matrix_queue.push_back(diagonal(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    matrix_queue.push_back(diagonal(32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000));
    matrix_queue.push_back('0);
    matrix_queue.push_back({9{32'h7FFF_FFFF}});
    matrix_queue.push_back({9{32'h8000_0000}});
    matrix_queue.push_back(diagonal(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    matrix_queue.push_back(diagonal(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    // Tiny elements give an inverse out of range in both directions.
    matrix_queue.push_back(diagonal(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    matrix_queue.push_back(diagonal(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001));
    matrix_queue.push_back(diagonal(32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFF));
    matrix_queue.push_back(diagonal(32'h0000_0100, 32'h0001_0000, 32'h0001_0000));
    m = diagonal(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    m[96 +: 32] = 32'h8000_0000;
    m[224 +: 32] = 32'h7FFF_FFFF;
    matrix_queue.push_back(m);
    // Two equal columns: singular with nonzero content.
    m = {32'h0003_0000, 32'h0005_0000, 32'hFFFE_0000, 32'h0001_0000, 32'h0004_0000,
         32'h0007_0000, 32'h0001_0000, 32'h0004_0000, 32'h0007_0000};
    matrix_queue.push_back(m);
    for (i = 0; i < 8; i++) matrix_queue.push_back({9{32'h1}} << (32 * i));
    matrix_queue.push_back({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom(), $urandom()});
    for (i = 0; i < 1500; i++) matrix_queue.push_back(random_matrix());
    stimulus_done = 1'b1;
  end

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (matrix_queue.size() > 0 &&
          ((cycle_count > 3000 && cycle_count < 6000) || $urandom_range(0, 99) >= 10)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= matrix_queue.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= (cycle_count > 4000 && cycle_count < 7000) ||
                          $urandom_range(0, 99) >= 10;
  end

  // Monitor: predict on each accepted request, compare each accepted result.
  always @(posedge clk) begin
    logic [289:0] want;
    if (rst) begin
      cycle_count <= 0;
      idle_cycles <= 0;
      mismatches  <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (s_axis_tvalid && s_axis_tready) inverse_queue.push_back(invert(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (inverse_queue.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h", m_axis_tdata);
          mismatches <= mismatches + 1;
        end else begin
          want = inverse_queue.pop_front();
          if (want != {m_axis_tuser, m_axis_tdata}) begin
            if (mismatches < 10)
              $display("mismatch: expected user %b data %h, got user %b data %h",
                       want[289:288], want[287:0], m_axis_tuser, m_axis_tdata);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("[matrix3_inverse_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    wait (stimulus_done);
    wait (matrix_queue.size() == 0 && !s_axis_tvalid && inverse_queue.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && inverse_queue.size() == 0) begin
      $display("[matrix3_inverse_unit] OK");
    end else begin
      $display("[matrix3_inverse_unit] ERROR");
    end
    $finish;
  end

endmodule
